// ===== sv/bpc_pkg.sv =====
// Shared constants, config codes and fixed-point helper for the palette colouriser.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int COUNT_W    = 24;
  localparam int LIMIT_W    = 16;
  localparam int GAIN_W     = 8;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Q1.16 quantities run from 0 to 1.0 inclusive
  localparam int Q_W = 17;
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  // gain product width: 255 * 17 * 255 needs 21 bits
  localparam int GK_W   = 21;
  localparam int PROD_W = GK_W + Q_W;

  // channel weights with the 255 scale folded in (blue is 8.5, kept as 17 and a wider shift)
  localparam logic [GK_W-1:0] RED_K   = 21'd2295;
  localparam logic [GK_W-1:0] GREEN_K = 21'd3825;
  localparam logic [GK_W-1:0] BLUE_K  = 21'd4335;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd100;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 4'd3;

  // pipeline depths
  localparam int DIV_LAT   = Q_W + 2;
  localparam int POLY_LAT  = 3;
  localparam int SHADE_LAT = 2;

  // truncating Q1.16 multiply
  function automatic logic [Q_W-1:0] q16_mul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = a * b;
    return p[Q_W+15:16];
  endfunction

endpackage

// ===== sv/bpc_div.sv =====
// Pipelined restoring divider producing the clamped Q1.16 position t and 1 - t.
`timescale 1ns / 1ps
module bpc_div #(
  parameter int FRACTION_BITS = bpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_vld,
  input  logic [bpc_pkg::COUNT_W-1:0]               in_count,
  input  logic [bpc_pkg::LIMIT_W+FRACTION_BITS-1:0] den,
  output logic                                      out_vld,
  output logic [bpc_pkg::Q_W-1:0]                   out_t,
  output logic [bpc_pkg::Q_W-1:0]                   out_u
);

  localparam int DEN_W = bpc_pkg::LIMIT_W + FRACTION_BITS;
  localparam int HI_W  = bpc_pkg::COUNT_W - 1;
  localparam int CMP_W = (DEN_W > HI_W) ? DEN_W : HI_W;
  localparam int STEPS = bpc_pkg::Q_W;

  // stage 0: count<<16 >= den<<17 means the quotient is far above one
  logic [CMP_W-1:0] hi_ext;
  logic             ovf_nxt;
  logic [DEN_W-1:0] rem0_nxt;

  assign hi_ext   = CMP_W'(in_count[bpc_pkg::COUNT_W-1:1]);
  assign ovf_nxt  = hi_ext >= CMP_W'(den);
  assign rem0_nxt = DEN_W'(hi_ext);

  logic [STEPS:0]          vld_r;
  logic [STEPS:0]          ovf_r;
  logic                    lsb_r;
  logic [DEN_W-1:0]        rem_r [STEPS];
  logic [bpc_pkg::Q_W-1:0] q_r   [1:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    ovf_r[0] <= ovf_nxt;
    rem_r[0] <= rem0_nxt;
    lsb_r    <= in_count[0];
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [DEN_W:0] sh;
    logic           take;

    assign sh   = {rem_r[k-1], (k == 1) ? lsb_r : 1'b0};
    assign take = sh >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      ovf_r[k] <= ovf_r[k-1];
    end

    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        q_r[k] <= {{(bpc_pkg::Q_W-1){1'b0}}, take};
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        q_r[k] <= {q_r[k-1][bpc_pkg::Q_W-2:0], take};
      end
    end

    if (k < STEPS) begin : g_rem
      logic [DEN_W-1:0] rem_nxt;
      assign rem_nxt = take ? DEN_W'(sh - {1'b0, den}) : DEN_W'(sh);
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
      end
    end
  end

  // clamp to one and form the complement
  logic                    t_vld_r;
  logic [bpc_pkg::Q_W-1:0] t_nxt, u_nxt, t_r, u_r;

  assign t_nxt = (ovf_r[STEPS] || (q_r[STEPS] > bpc_pkg::ONE_Q16)) ? bpc_pkg::ONE_Q16
                                                                  : q_r[STEPS];
  assign u_nxt = bpc_pkg::ONE_Q16 - t_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else begin
      t_vld_r <= vld_r[STEPS];
    end
    t_r <= t_nxt;
    u_r <= u_nxt;
  end

  assign out_vld = t_vld_r;
  assign out_t   = t_r;
  assign out_u   = u_r;

endmodule

// ===== sv/bpc_poly.sv =====
// Three-stage Bernstein basis evaluation: u*t^3, u^2*t^2, u^3*t in Q1.16.
`timescale 1ns / 1ps
module bpc_poly (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [bpc_pkg::Q_W-1:0] in_t,
  input  logic [bpc_pkg::Q_W-1:0] in_u,
  output logic                    out_vld,
  output logic [bpc_pkg::Q_W-1:0] out_pr,
  output logic [bpc_pkg::Q_W-1:0] out_pg,
  output logic [bpc_pkg::Q_W-1:0] out_pb
);

  logic [2:0] vld_r;

  // stage 1: squares
  logic [bpc_pkg::Q_W-1:0] t1_r, u1_r, t2_r, u2_r;
  // stage 2: cubes and the green term
  logic [bpc_pkg::Q_W-1:0] t_b_r, u_b_r, t3_r, u3_r, pg_b_r;
  // stage 3: red and blue terms
  logic [bpc_pkg::Q_W-1:0] pr_r, pg_r, pb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_vld};
    end
    t1_r   <= in_t;
    u1_r   <= in_u;
    t2_r   <= bpc_pkg::q16_mul(in_t, in_t);
    u2_r   <= bpc_pkg::q16_mul(in_u, in_u);

    t_b_r  <= t1_r;
    u_b_r  <= u1_r;
    t3_r   <= bpc_pkg::q16_mul(t2_r, t1_r);
    u3_r   <= bpc_pkg::q16_mul(u2_r, u1_r);
    pg_b_r <= bpc_pkg::q16_mul(u2_r, t2_r);

    pr_r   <= bpc_pkg::q16_mul(u_b_r, t3_r);
    pb_r   <= bpc_pkg::q16_mul(u3_r, t_b_r);
    pg_r   <= pg_b_r;
  end

  assign out_vld = vld_r[2];
  assign out_pr  = pr_r;
  assign out_pg  = pg_r;
  assign out_pb  = pb_r;

endmodule

// ===== sv/bpc_shade.sv =====
// Gain multiply, scale and saturate of the three channels, with the result register.
`timescale 1ns / 1ps
module bpc_shade (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [bpc_pkg::Q_W-1:0]  in_pr,
  input  logic [bpc_pkg::Q_W-1:0]  in_pg,
  input  logic [bpc_pkg::Q_W-1:0]  in_pb,
  input  logic [bpc_pkg::GK_W-1:0] gk_red,
  input  logic [bpc_pkg::GK_W-1:0] gk_green,
  input  logic [bpc_pkg::GK_W-1:0] gk_blue,
  output logic                     out_vld,
  output logic [bpc_pkg::CH_W-1:0] out_red,
  output logic [bpc_pkg::CH_W-1:0] out_green,
  output logic [bpc_pkg::CH_W-1:0] out_blue
);

  localparam int PW = bpc_pkg::PROD_W;

  logic          prod_vld_r;
  logic [PW-1:0] pr_prod_r, pg_prod_r, pb_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= in_vld;
    end
    pr_prod_r <= PW'(gk_red)   * PW'(in_pr);
    pg_prod_r <= PW'(gk_green) * PW'(in_pg);
    pb_prod_r <= PW'(gk_blue)  * PW'(in_pb);
  end

  // red and green scale by 2^-16, blue by 2^-17
  logic [bpc_pkg::CH_W-1:0] red_nxt, green_nxt, blue_nxt;

  assign red_nxt   = (|pr_prod_r[PW-1:24]) ? '1 : pr_prod_r[23:16];
  assign green_nxt = (|pg_prod_r[PW-1:24]) ? '1 : pg_prod_r[23:16];
  assign blue_nxt  = (|pb_prod_r[PW-1:25]) ? '1 : pb_prod_r[24:17];

  logic                     vld_r;
  logic [bpc_pkg::CH_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= prod_vld_r;
    end
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_vld   = vld_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ===== sv/bernstein_palette_colorizer_core.sv =====
// Top level of the Bernstein-polynomial palette colouriser.
`timescale 1ns / 1ps
// Usage
//   Input: drive in_smooth_count and pulse start; the item is taken at an edge
//   where start is high and busy is low. busy is low whenever reset is released,
//   so an item may be offered every cycle.
//   Result: out_valid strobes for one cycle with out_red/green/blue and
//   out_packed_color (red in bits 23:16, blue in 7:0). Results come back in order.
//   The receiver cannot hold results off and the pipe never stalls.
//   Stages: input register, 19 divider stages, 3 polynomial stages, 2 gain stages.
//   Throughput: one item per cycle.
//   The divider's 17 restoring stages (one quotient bit per stage) set the depth.
// Configuration
//   cfg_valid/cfg_ready write register cfg_index with cfg_data: 0 iteration limit,
//   1..3 red/green/blue gain. cfg_ready is always high; unknown indexes are
//   dropped. Write only while no item is in flight.
// Reset
//   Synchronous, active low: limit 100, gains 1, all in-flight items discarded.
module bernstein_palette_colorizer_core #(
  parameter int FRACTION_BITS = bpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bpc_pkg::COUNT_W-1:0]    in_smooth_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic [bpc_pkg::CH_W-1:0]       out_red,
  output logic [bpc_pkg::CH_W-1:0]       out_green,
  output logic [bpc_pkg::CH_W-1:0]       out_blue,
  output logic [3*bpc_pkg::CH_W-1:0]     out_packed_color
);

  localparam int DEN_W = bpc_pkg::LIMIT_W + FRACTION_BITS;
  localparam int LAT   = 1 + bpc_pkg::DIV_LAT + bpc_pkg::POLY_LAT + bpc_pkg::SHADE_LAT;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bpc_pkg::LIMIT_W-1:0] limit_r;
  logic [bpc_pkg::GAIN_W-1:0]  red_gain_r, green_gain_r, blue_gain_r;
  logic                        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= bpc_pkg::LIMIT_RST;
      red_gain_r   <= bpc_pkg::GAIN_RST;
      green_gain_r <= bpc_pkg::GAIN_RST;
      blue_gain_r  <= bpc_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::CFG_LIMIT: limit_r      <= cfg_data;
        bpc_pkg::CFG_RED:   red_gain_r   <= cfg_data[bpc_pkg::GAIN_W-1:0];
        bpc_pkg::CFG_GREEN: green_gain_r <= cfg_data[bpc_pkg::GAIN_W-1:0];
        bpc_pkg::CFG_BLUE:  blue_gain_r  <= cfg_data[bpc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived constants, re-registered from the config every cycle. The user must
  // change config only while idle (not enforced), so the lag never meets an item.
  logic [bpc_pkg::LIMIT_W-1:0] limit_eff;
  logic [DEN_W-1:0]            den_nxt, den_r;
  logic [bpc_pkg::GK_W-1:0]    gk_red_nxt, gk_green_nxt, gk_blue_nxt;
  logic [bpc_pkg::GK_W-1:0]    gk_red_r, gk_green_r, gk_blue_r;

  // a zero limit behaves as one
  assign limit_eff    = (limit_r == '0) ? bpc_pkg::LIMIT_W'(1) : limit_r;
  assign den_nxt      = DEN_W'(limit_eff) << FRACTION_BITS;
  assign gk_red_nxt   = bpc_pkg::GK_W'(red_gain_r)   * bpc_pkg::RED_K;
  assign gk_green_nxt = bpc_pkg::GK_W'(green_gain_r) * bpc_pkg::GREEN_K;
  assign gk_blue_nxt  = bpc_pkg::GK_W'(blue_gain_r)  * bpc_pkg::BLUE_K;

  always_ff @(posedge clk) begin
    den_r      <= den_nxt;
    gk_red_r   <= gk_red_nxt;
    gk_green_r <= gk_green_nxt;
    gk_blue_r  <= gk_blue_nxt;
  end

  // ---------------------------------------------------------------------------
  // Input register: no backpressure anywhere, so busy only covers reset
  // ---------------------------------------------------------------------------
  logic                        in_vld_nxt, in_vld_r;
  logic [bpc_pkg::COUNT_W-1:0] count_r;

  assign busy       = ~rst_n;
  assign in_vld_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    count_r <= in_smooth_count;
  end

  // ---------------------------------------------------------------------------
  // t = min(1, count / (limit * 2^FRACTION_BITS)) in Q1.16
  // ---------------------------------------------------------------------------
  logic                    t_vld;
  logic [bpc_pkg::Q_W-1:0] t_q, u_q;

  bpc_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld_r),
    .in_count(count_r),
    .den     (den_r),
    .out_vld (t_vld),
    .out_t   (t_q),
    .out_u   (u_q)
  );

  // ---------------------------------------------------------------------------
  // Basis terms
  // ---------------------------------------------------------------------------
  logic                    p_vld;
  logic [bpc_pkg::Q_W-1:0] pr_q, pg_q, pb_q;

  bpc_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (t_vld),
    .in_t   (t_q),
    .in_u   (u_q),
    .out_vld(p_vld),
    .out_pr (pr_q),
    .out_pg (pg_q),
    .out_pb (pb_q)
  );

  // ---------------------------------------------------------------------------
  // Gain, saturate, result register
  // ---------------------------------------------------------------------------
  bpc_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p_vld),
    .in_pr    (pr_q),
    .in_pg    (pg_q),
    .in_pb    (pb_q),
    .gk_red   (gk_red_r),
    .gk_green (gk_green_r),
    .gk_blue  (gk_blue_r),
    .out_vld  (out_valid),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue)
  );

  // channels saturate separately, so packing is a plain concatenation
  assign out_packed_color = {out_red, out_green, out_blue};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, LAT))
    else $error("result strobe does not match accepted item");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start && !busy && (in_smooth_count == '0), LAT)
      |-> (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("zero count gave a non-black colour");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld |-> (t_q <= bpc_pkg::ONE_Q16) && (32'(t_q) + 32'(u_q) == 32'(bpc_pkg::ONE_Q16)))
    else $error("position out of range or complement wrong");

endmodule

// ===== dv/bernstein_palette_colorizer_core_tb.sv =====
// Self-checking testbench for the Bernstein palette colouriser: directed corners, random palettes.
`timescale 1ns / 1ps
module bernstein_palette_colorizer_core_tb;
  import bpc_pkg::*;

  // ---------------------------------------------------------------------------
  // Timing and run limits
  // ---------------------------------------------------------------------------
  localparam int HALF_PERIOD  = 10;
  localparam int PIPE_LAT     = 25;       // accept edge to result edge
  localparam int SETTLE_CYC   = PIPE_LAT + 6;
  localparam int CYCLE_LIMIT  = 400000;   // watchdog bound on the whole run
  localparam int ERR_SHOWN    = 40;       // cap on printed mismatch reports
  localparam int FRAC_BITS    = FRACTION_BITS_DEF;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;

  // per-pixel colour as the core presents it
  typedef struct packed {
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [3*CH_W-1:0] packed_color;
  } colour_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [COUNT_W-1:0]    in_smooth_count = '0;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  out_valid;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic [3*CH_W-1:0]     out_packed_color;

  bernstein_palette_colorizer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_smooth_count  (in_smooth_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_packed_color (out_packed_color)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the palette registers, updated on each accepted write
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_q      = LIMIT_RST;
  logic [GAIN_W-1:0]  red_gain_q   = GAIN_RST;
  logic [GAIN_W-1:0]  green_gain_q = GAIN_RST;
  logic [GAIN_W-1:0]  blue_gain_q  = GAIN_RST;

  colour_t pending_colours[$];   // predicted colours, oldest first
  colour_t head_colour;
  int unsigned pixels_sent   = 0;
  int unsigned colours_seen  = 0;
  int unsigned bad_results   = 0;
  int unsigned settings_used = 1;  // reset values count as the first
  int unsigned cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // Colour predictor: Q1.16 normalised count, Bernstein weights, gain, clamp
  // ---------------------------------------------------------------------------
  function automatic colour_t shade_count(input logic [COUNT_W-1:0] count);
    logic [63:0] lim, den, t, u, t2, t3, u2, u3, wr, wg, wb, r, g, b;
    colour_t c;
    lim = (limit_q == '0) ? 64'd1 : 64'(limit_q);   // a zero limit acts as one
    den = lim << FRAC_BITS;
    t   = (64'(count) << 16) / den;
    if (t > 64'h10000)
      t = 64'h10000;                                // count beyond limit: t pinned at one
    u   = 64'h10000 - t;
    t2  = (t * t) >> 16;
    t3  = (t2 * t) >> 16;
    u2  = (u * u) >> 16;
    u3  = (u2 * u) >> 16;
    wr  = (u * t3) >> 16;
    wg  = (u2 * t2) >> 16;
    wb  = (u3 * t) >> 16;
    r   = (64'(red_gain_q)   * 64'd9  * 64'd255 * wr) >> 16;
    g   = (64'(green_gain_q) * 64'd15 * 64'd255 * wg) >> 16;
    b   = (64'(blue_gain_q)  * 64'd17 * 64'd255 * wb) >> 17;   // 8.5 held as 17 / 2
    c.red          = (r > 64'd255) ? 8'hFF : r[7:0];
    c.green        = (g > 64'd255) ? 8'hFF : g[7:0];
    c.blue         = (b > 64'd255) ? 8'hFF : b[7:0];
    c.packed_color = {c.red, c.green, c.blue};    // saturation never spills across bytes
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: one compare per strobe against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got, inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (bad_results < ERR_SHOWN)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bit bad;
    bad = 1'b0;
    if (rst_n && out_valid) begin
      colours_seen++;
      if (pending_colours.size() == 0) begin
        bad = 1'b1;
        if (bad_results < ERR_SHOWN)
          $error("colour strobe with no pixel outstanding (0x%0h)", out_packed_color);
      end else begin
        head_colour = pending_colours.pop_front();
        compare_field("red",          head_colour.red,          out_red,          bad);
        compare_field("green",        head_colour.green,        out_green,        bad);
        compare_field("blue",         head_colour.blue,         out_blue,         bad);
        compare_field("packed_color", head_colour.packed_color, out_packed_color, bad);
      end
      if (bad) begin
        bad_results++;
        if (bad_results == ERR_SHOWN)
          $display("further mismatch reports suppressed");
      end
    end
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colours outstanding",
               cycle_count, pending_colours.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------
  // offer one pixel; start is left high so back-to-back items need no gap
  task automatic send_pixel(input logic [COUNT_W-1:0] count);
    @(negedge clk);
    start           <= 1'b1;
    in_smooth_count <= count;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_colours.push_back(shade_count(count));
    pixels_sent++;
  endtask

  // drop start for an idle gap set by n, scrambling the data lines meanwhile
  task automatic idle_inputs(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      start           <= 1'b0;
      in_smooth_count <= COUNT_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // drop start, wait for every colour to come back, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // one register write; caller has already settled the pipe
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LIMIT: limit_q      = data;
      CFG_RED:   red_gain_q   = data[GAIN_W-1:0];
      CFG_GREEN: green_gain_q = data[GAIN_W-1:0];
      CFG_BLUE:  blue_gain_q  = data[GAIN_W-1:0];
      default:   ;   // unmapped index: no register changes
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_palette(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] rg,
                               input logic [CFG_DATA_W-1:0] gg, input logic [CFG_DATA_W-1:0] bg);
    settle();
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_RED,   rg);
    write_reg(CFG_GREEN, gg);
    write_reg(CFG_BLUE,  bg);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset palette: limit 100, unit gains; t at 0, quarters, just below, at and above one
  task automatic test_reset_palette();
    send_pixel(24'd0);
    send_pixel(24'd1);
    send_pixel(24'd6400);
    send_pixel(24'd12800);
    send_pixel(24'd19200);
    send_pixel(24'd25599);
    send_pixel(24'd25600);
    send_pixel(24'd25601);
    send_pixel(24'hFFFFFF);
  endtask

  // zero limit behaves as a limit of one
  task automatic test_zero_limit();
    apply_palette(16'd0, 16'd1, 16'd1, 16'd1);
    send_pixel(24'd0);
    send_pixel(24'd128);
    send_pixel(24'd255);
    send_pixel(24'd256);
    send_pixel(24'd257);
  endtask

  // full gains push every channel past 255 near its peak; zero gains give black
  task automatic test_gain_clamp();
    apply_palette(16'd100, 16'hFFFF, 16'h00FF, 16'hA5FF);
    send_pixel(24'd12800);
    send_pixel(24'd19200);
    send_pixel(24'd6400);
    send_pixel(24'd3);
    apply_palette(16'd100, 16'hFF00, 16'h0000, 16'h5A00);
    send_pixel(24'd12800);
  endtask

  // widest limit: full-scale count lands just past one
  task automatic test_widest_limit();
    apply_palette(16'hFFFF, 16'd200, 16'd37, 16'd90);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h7FFFFF);
    send_pixel(24'd1);
  endtask

  // writes to unmapped indexes must leave the palette alone
  task automatic test_unmapped_index();
    settle();
    for (int i = CFG_BLUE + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    send_pixel(24'h400000);
    send_pixel(24'hC00000);
  endtask

  // random palettes, first two pinned at the register extremes
  task automatic test_random_palettes();
    logic [CFG_DATA_W-1:0] lim, gain [3];
    int unsigned span, top, pick, gap;
    bit burst;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          lim = 16'd1;
          gain = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        end
        1: begin
          lim = 16'hFFFF;
          gain = '{16'h0000, 16'h0000, 16'h0000};
        end
        2: begin
          lim = 16'd0;
          gain = '{CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom)};
        end
        default: begin
          pick = $urandom_range(0, 3);
          lim = (pick == 0) ? CFG_DATA_W'($urandom_range(1, 8)) :
                (pick == 1) ? CFG_DATA_W'($urandom_range(9, 1000)) :
                              CFG_DATA_W'($urandom);
          for (int k = 0; k < 3; k++) begin
            gain[k] = CFG_DATA_W'($urandom);
            if ($urandom_range(0, 3) == 0)
              gain[k][GAIN_W-1:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end
        end
      endcase
      apply_palette(lim, gain[0], gain[1], gain[2]);
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(CFG_BLUE + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));

      // most counts fall within the limit, a little past it, some anywhere
      span  = ((limit_q == '0) ? 32'd1 : 32'(limit_q)) << FRAC_BITS;
      top   = span + span / 8 + 2;
      if (top > 32'hFFFFFF)
        top = 32'hFFFFFF;
      burst = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0)
          burst = ($urandom_range(0, 3) == 0);    // some stretches run back to back
        pick = $urandom_range(0, 99);
        if (pick < 75)
          send_pixel(COUNT_W'($urandom_range(0, top)));
        else if (pick < 85)
          send_pixel(COUNT_W'($urandom_range(span > 4 ? span - 4 : 0, span + 4)));
        else
          send_pixel(COUNT_W'($urandom));
        pick = $urandom_range(0, 99);
        gap  = (burst || pick < 55) ? 0 :
               (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        idle_inputs(gap);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_palette();
    test_zero_limit();
    test_gain_clamp();
    test_widest_limit();
    test_unmapped_index();
    test_random_palettes();

    settle();
    $display("pixels sent: %0d, colours checked: %0d, palette settings: %0d",
             pixels_sent, colours_seen, settings_used);
    $display("limits from 0 to 65535, gains 0 to 255, counts across the full 24-bit range");
    if (bad_results == 0 && pending_colours.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
